FILE: sv/assert_macros.svh
// Assertion macros shared by the slab allocator RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fcsa_pkg.sv
// Package for the four-class slab allocator: widths, codes, types.
// No dependencies; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package fcsa_pkg;

  localparam int BLOCKS_PER_CLASS = 1024;
  localparam int NUM_CLASSES      = 4;
  localparam int SIZE_REGS        = 4;

  localparam int ACT_CLASSES = (NUM_CLASSES < SIZE_REGS) ? NUM_CLASSES : SIZE_REGS;
  localparam int CLS_W       = (ACT_CLASSES > 1) ? $clog2(ACT_CLASSES) : 1;
  localparam int PTR_W       = $clog2(BLOCKS_PER_CLASS);
  localparam int CNT_W       = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int ADDR_W      = CLS_W + PTR_W;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;

  localparam int SIZE_W   = 16;
  localparam int IDX_W    = 10;
  localparam int SC_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] CLASS_SIZE_RST [SIZE_REGS] = '{
    16'd64, 16'd256, 16'd1024, 16'd4096
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_SIZE_0 = 2'd0,
    CFG_CLASS_SIZE_1 = 2'd1,
    CFG_CLASS_SIZE_2 = 2'd2,
    CFG_CLASS_SIZE_3 = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASS,
    S_ACCESS,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch_req;
    logic classify;
    logic access;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: sv/fcsa_ifs.sv
// Request and result channel interfaces for the slab allocator.
// Depends on fcsa_pkg.
`timescale 1ns / 1ps

interface fcsa_req_if import fcsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] req_size;
  logic [IDX_W-1:0]  block_index;

  modport source (output valid, func, req_size, block_index, input ready);
  modport sink   (input valid, func, req_size, block_index, output ready);
endinterface

interface fcsa_rsp_if import fcsa_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [SC_W-1:0]  size_class;
  logic [IDX_W-1:0] granted_index;

  modport source (output valid, status, size_class, granted_index, input ready);
  modport sink   (input valid, status, size_class, granted_index, output ready);
endinterface

FILE: sv/fcsa_ctrl.sv
// Sequencer for the slab allocator: steps one request through class select,
// stack access and result load. Depends on fcsa_pkg.
`timescale 1ns / 1ps

module fcsa_ctrl import fcsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CLASS;
      end
      S_CLASS:  state_nxt = S_ACCESS;
      S_ACCESS: state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
      end
      S_CLASS:  cmd.classify = 1'b1;
      S_ACCESS: cmd.access   = 1'b1;
      S_DONE:   cmd.load_out = !sts.out_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/fcsa_datapath.sv
// Datapath of the slab allocator: size registers, class select, per-class
// free counts, the free-index stack memory and the result register. Depends on fcsa_pkg.
`timescale 1ns / 1ps

module fcsa_datapath import fcsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 in_func,
  input  logic [SIZE_W-1:0]    in_req_size,
  input  logic [IDX_W-1:0]     in_block_index,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output status_t              out_status,
  output logic [SC_W-1:0]      out_size_class,
  output logic [IDX_W-1:0]     out_granted_index
);

  logic [SIZE_W-1:0] class_size_r [SIZE_REGS];
  logic [CNT_W-1:0]  count_r      [ACT_CLASSES];
  logic [CNT_W-1:0]  min_r        [ACT_CLASSES];
  logic [IDX_W-1:0]  stack_mem    [MEM_DEPTH];

  func_t             func_r;
  logic [SIZE_W-1:0] size_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CLS_W-1:0]  cls_r;
  logic              hit_r;
  status_t           st_r;
  logic              low_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [IDX_W-1:0]  rd_data_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [SC_W-1:0]   out_class_r;
  logic [IDX_W-1:0]  out_granted_r;

  logic [CLS_W-1:0]  pick;
  logic              pick_hit;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  mn;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  min_nxt;
  status_t           st_nxt;
  logic              low_nxt;
  logic              rd_en;
  logic              wr_en;
  logic [PTR_W-1:0]  ptr;
  logic [ADDR_W-1:0] addr;

  // First fitting class wins.
  always_comb begin
    pick     = '0;
    pick_hit = 1'b0;
    for (int c = ACT_CLASSES - 1; c >= 0; c--) begin
      if (size_r <= class_size_r[c]) begin
        pick     = CLS_W'(c);
        pick_hit = 1'b1;
      end
    end
  end

  assign cnt  = count_r[cls_r];
  assign mn   = min_r[cls_r];
  assign addr = {cls_r, ptr};

  // Entries below the lowest count ever reached were never written and hold
  // their own position.
  always_comb begin
    st_nxt  = ST_OK;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    low_nxt = 1'b0;
    cnt_nxt = cnt;
    min_nxt = mn;
    ptr     = PTR_W'(cnt);
    if (!hit_r) begin
      st_nxt = ST_TOO_LARGE;
    end else if (func_r == FUNC_ALLOC) begin
      ptr = PTR_W'(cnt - CNT_W'(1));
      if (cnt == '0) begin
        st_nxt = ST_EMPTY;
      end else begin
        rd_en   = cmd.access;
        cnt_nxt = cnt - CNT_W'(1);
        low_nxt = (cnt == mn);
        if (cnt == mn) min_nxt = cnt - CNT_W'(1);
      end
    end else begin
      if (cnt >= CNT_W'(BLOCKS_PER_CLASS)) begin
        st_nxt = ST_FULL;
      end else begin
        wr_en   = cmd.access;
        cnt_nxt = cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SIZE_REGS; r++) class_size_r[r] <= CLASS_SIZE_RST[r];
      for (int c = 0; c < ACT_CLASSES; c++) begin
        count_r[c] <= CNT_W'(BLOCKS_PER_CLASS);
        min_r[c]   <= CNT_W'(BLOCKS_PER_CLASS);
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CLASS_SIZE_0: class_size_r[0] <= cfg_wdata;
          CFG_CLASS_SIZE_1: class_size_r[1] <= cfg_wdata;
          CFG_CLASS_SIZE_2: class_size_r[2] <= cfg_wdata;
          CFG_CLASS_SIZE_3: class_size_r[3] <= cfg_wdata;
          default:          class_size_r[0] <= class_size_r[0];
        endcase
      end
      if (cmd.access && hit_r) begin
        count_r[cls_r] <= cnt_nxt;
        min_r[cls_r]   <= min_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      func_r <= func_t'(in_func);
      size_r <= in_req_size;
      idx_r  <= in_block_index;
    end
    if (cmd.classify) begin
      cls_r <= pick;
      hit_r <= pick_hit;
    end
    if (cmd.access) begin
      st_r  <= st_nxt;
      low_r <= low_nxt;
      ptr_r <= ptr;
    end
    if (cmd.load_out) begin
      out_status_r  <= st_r;
      out_class_r   <= SC_W'(cls_r);
      if (st_r == ST_OK && func_r == FUNC_ALLOC) begin
        out_granted_r <= low_r ? IDX_W'(ptr_r) : rd_data_r;
      end else begin
        out_granted_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[addr] <= idx_r;
    if (rd_en) rd_data_r <= stack_mem[addr];
  end

  assign sts.out_busy      = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_size_class    = out_class_r;
  assign out_granted_index = out_granted_r;

endmodule

FILE: sv/four_class_slab_allocator.sv
// Four-class slab allocator: a request is routed to the first class whose size register
// covers it, an allocate pops a free block index from that class's LIFO stack and a free
// pushes one back. Each accepted word steps through four states (accept, class select, stack access,
// result load), an order set by the registered read of the single-port stack memory; a stalled result
// holds it in result load, and the next request is accepted while a result waits to be
// taken. Stacks start full with the highest index on top, with no clearing pass after reset:
// a per-class low-water mark stands in for the reset contents. Double frees are not caught.
// Depends on fcsa_pkg, fcsa_ifs, fcsa_ctrl, fcsa_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_class_slab_allocator import fcsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  fcsa_req_if.sink             in_ch,
  fcsa_rsp_if.source           out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fcsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcsa_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_ch.func),
    .in_req_size       (in_ch.req_size),
    .in_block_index    (in_ch.block_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_size_class    (out_ch.size_class),
    .out_granted_index (out_ch.granted_index)
  );

  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "request accepted while another is in flight")
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.load_out, !(out_ch.valid && !out_ch.ready), "result overwrote a word not yet taken")
  `ASSERT_IMPL(a_grant_only_ok, clk, rst_n, out_ch.valid && out_ch.status != ST_OK, out_ch.granted_index == '0, "index granted on a failed request")
  `ASSERT_IMPL(a_too_large_class, clk, rst_n, out_ch.valid && out_ch.status == ST_TOO_LARGE, out_ch.size_class == '0, "class set on an oversized request")

endmodule
